[sv/segment_obb_overlap_sat_assert.svh]
// Assertion macros shared by the segment to oriented box overlap block.
`ifndef SEGMENT_OBB_OVERLAP_SAT_ASSERT_SVH
`define SEGMENT_OBB_OVERLAP_SAT_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define SOBB_ASSERT_IMM(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("segment_obb_overlap_sat: same-cycle check failed");

// Consequence must hold in the cycle after the antecedent.
`define SOBB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("segment_obb_overlap_sat: next-cycle check failed");

`endif

[sv/sobb_pkg.sv]
package sobb_pkg;

  localparam int COORD_BITS_DEF     = 16;
  localparam int AXIS_FRAC_BITS_DEF = 14;

  localparam int REG_W  = 48;
  localparam int HALF_W = 16;
  localparam int CFG_DW = 64;
  localparam int CFG_AW = 6;

  typedef enum logic [2:0] {
    REG_BOX_CENTER  = 3'd0,
    REG_AXIS_FIRST  = 3'd1,
    REG_AXIS_SECOND = 3'd2,
    REG_AXIS_THIRD  = 3'd3,
    REG_HALF_FIRST  = 3'd4,
    REG_HALF_SECOND = 3'd5,
    REG_HALF_THIRD  = 3'd6
  } reg_idx_t;

endpackage

[sv/sobb_in_if.sv]
interface sobb_in_if #(
  parameter int COORD_BITS = sobb_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] start_z;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic signed [COORD_BITS-1:0] end_z;

  modport source (
    output valid, start_x, start_y, start_z, end_x, end_y, end_z,
    input  ready
  );

  modport sink (
    input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
    output ready
  );
endinterface

[sv/sobb_out_if.sv]
interface sobb_out_if;
  logic valid;
  logic ready;
  logic overlap;

  modport source (
    output valid, overlap,
    input  ready
  );

  modport sink (
    input  valid, overlap,
    output ready
  );
endinterface

[sv/segment_obb_overlap_sat.sv]
// Throughput: one segment per cycle while out_res.ready holds; each of the 8 stages holds one beat and moves on
// whenever the stage after it is free, so bubbles close up under output back-pressure.
// Reset (rst_n low at a clock edge) empties the pipeline and returns the box to
// its defaults: centre at the origin, identity axes and zero half-lengths.
`include "segment_obb_overlap_sat_assert.svh"

module segment_obb_overlap_sat #(
  parameter int COORD_BITS     = sobb_pkg::COORD_BITS_DEF,
  parameter int AXIS_FRAC_BITS = sobb_pkg::AXIS_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sobb_in_if.sink                       in_seg,
  sobb_out_if.source                    out_res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sobb_pkg::CFG_AW-1:0]   paddr,
  input  logic [sobb_pkg::CFG_DW-1:0]   pwdata,
  output logic [sobb_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int REG_W  = sobb_pkg::REG_W;
  localparam int HALF_W = sobb_pkg::HALF_W;
  localparam int CFG_DW = sobb_pkg::CFG_DW;
  localparam int CFG_AW = sobb_pkg::CFG_AW;

  localparam int CW   = COORD_BITS;
  localparam int AW   = AXIS_FRAC_BITS + 2;
  localparam int HW   = (CW < HALF_W) ? CW : HALF_W;
  localparam int PTW  = CW + 1;
  localparam int QW   = PTW + AW;
  localparam int DW   = QW + 2;
  localparam int MW   = DW + 1;
  localparam int LO   = MW / 2;
  localparam int HI   = MW - LO;
  localparam int PLW  = MW + LO + 1;
  localparam int PHW  = MW + HI;
  localparam int PPW  = 2 * MW;
  localparam int RPW  = HW + MW;
  localparam int RW   = RPW + 1;
  localparam int XW   = PPW + 1;
  localparam int RSW  = RW + AXIS_FRAC_BITS + 1;
  localparam int CMPW = (XW > RSW) ? XW : RSW;
  localparam int FSW  = (MW > HW + AXIS_FRAC_BITS + 1) ? MW : HW + AXIS_FRAC_BITS + 1;
  localparam int FW   = FSW + 1;
  localparam int NS   = 8;

  localparam logic [63:0]      ONE_AX  = 64'd1 << AXIS_FRAC_BITS;
  localparam logic [REG_W-1:0] AX_RST0 = ONE_AX[REG_W-1:0];
  localparam logic [REG_W-1:0] AX_RST1 = REG_W'(ONE_AX << AW);
  localparam logic [REG_W-1:0] AX_RST2 = REG_W'(ONE_AX << (2 * AW));

  // Cross axes pair the box axes (second, third), (first, third), (first, second).
  localparam int PAIR_A [3] = '{1, 0, 0};
  localparam int PAIR_B [3] = '{2, 2, 1};

  // Configuration registers.
  logic [REG_W-1:0]   center_r;
  logic [REG_W-1:0]   axis_r [3];
  logic [HALF_W-1:0]  half_r [3];
  logic               cfg_wr;
  sobb_pkg::reg_idx_t cfg_idx;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = sobb_pkg::reg_idx_t'(paddr[CFG_AW-1:3]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r  <= '0;
      axis_r[0] <= AX_RST0;
      axis_r[1] <= AX_RST1;
      axis_r[2] <= AX_RST2;
      half_r[0] <= '0;
      half_r[1] <= '0;
      half_r[2] <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        sobb_pkg::REG_BOX_CENTER:  center_r  <= pwdata[REG_W-1:0];
        sobb_pkg::REG_AXIS_FIRST:  axis_r[0] <= pwdata[REG_W-1:0];
        sobb_pkg::REG_AXIS_SECOND: axis_r[1] <= pwdata[REG_W-1:0];
        sobb_pkg::REG_AXIS_THIRD:  axis_r[2] <= pwdata[REG_W-1:0];
        sobb_pkg::REG_HALF_FIRST:  half_r[0] <= pwdata[HALF_W-1:0];
        sobb_pkg::REG_HALF_SECOND: half_r[1] <= pwdata[HALF_W-1:0];
        sobb_pkg::REG_HALF_THIRD:  half_r[2] <= pwdata[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      sobb_pkg::REG_BOX_CENTER:  prdata = CFG_DW'(center_r);
      sobb_pkg::REG_AXIS_FIRST:  prdata = CFG_DW'(axis_r[0]);
      sobb_pkg::REG_AXIS_SECOND: prdata = CFG_DW'(axis_r[1]);
      sobb_pkg::REG_AXIS_THIRD:  prdata = CFG_DW'(axis_r[2]);
      sobb_pkg::REG_HALF_FIRST:  prdata = CFG_DW'(half_r[0]);
      sobb_pkg::REG_HALF_SECOND: prdata = CFG_DW'(half_r[1]);
      sobb_pkg::REG_HALF_THIRD:  prdata = CFG_DW'(half_r[2]);
      default:                   prdata = '0;
    endcase
  end

  // Unpacking of the box fields; bits above the register read as zero.
  logic [3*CW+REG_W-1:0] center_ext;
  logic [3*AW+REG_W-1:0] axis_ext [3];
  logic signed [CW-1:0]  cen [3];
  logic signed [AW-1:0]  comp [3][3];
  logic [HW-1:0]         hlen [3];
  logic signed [CW-1:0]  ept [2][3];

  always_comb begin
    center_ext = {{(3*CW){1'b0}}, center_r};
    for (int a = 0; a < 3; a++) begin
      axis_ext[a] = {{(3*AW){1'b0}}, axis_r[a]};
      cen[a]      = center_ext[a*CW +: CW];
      hlen[a]     = half_r[a][HW-1:0];
      for (int k = 0; k < 3; k++) begin
        comp[a][k] = axis_ext[a][k*AW +: AW];
      end
    end
    ept[0][0] = in_seg.start_x;
    ept[0][1] = in_seg.start_y;
    ept[0][2] = in_seg.start_z;
    ept[1][0] = in_seg.end_x;
    ept[1][1] = in_seg.end_y;
    ept[1][2] = in_seg.end_z;
  end

  // Pipeline flow control: a stage loads when it is empty or its successor loads.
  logic [NS:1]   vld_r;
  logic [NS+1:1] en;

  always_comb begin
    en[NS+1] = out_res.ready;
    for (int k = NS; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[1]) begin
        vld_r[1] <= in_seg.valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_seg.ready  = en[1];
  assign out_res.valid = vld_r[NS];

  // Stage 1: endpoints relative to the box centre.
  logic signed [PTW-1:0] pt_r [2][3];
  logic signed [PTW-1:0] pt_nxt [2][3];

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      for (int k = 0; k < 3; k++) begin
        pt_nxt[e][k] = PTW'(ept[e][k]) - PTW'(cen[k]);
      end
    end
  end

  // Stage 2: component products for the box-space projections.
  logic signed [QW-1:0] prod_r [2][3][3];
  logic signed [QW-1:0] prod_nxt [2][3][3];

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < 3; k++) begin
          prod_nxt[e][a][k] = QW'(pt_r[e][k]) * QW'(comp[a][k]);
        end
      end
    end
  end

  // Stage 3: dot products.
  logic signed [DW-1:0] dot_r [2][3];
  logic signed [DW-1:0] dot_nxt [2][3];

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      for (int a = 0; a < 3; a++) begin
        dot_nxt[e][a] = DW'(prod_r[e][a][0]) + DW'(prod_r[e][a][1]) + DW'(prod_r[e][a][2]);
      end
    end
  end

  // Stage 4: doubled midpoint and half-extent in box space.
  logic signed [MW-1:0] mid_r [3];
  logic signed [MW-1:0] ext_r [3];
  logic signed [MW-1:0] mid_nxt [3];
  logic signed [MW-1:0] ext_nxt [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mid_nxt[a] = MW'(dot_r[1][a]) + MW'(dot_r[0][a]);
      ext_nxt[a] = MW'(dot_r[1][a]) - MW'(dot_r[0][a]);
    end
  end

  // Stage 5: face axis tests and the split cross products.
  logic [MW-1:0]         mid_mag [3];
  logic [MW-1:0]         ext_mag [3];
  logic [2:0]            face_hit;
  logic                  sep5_r;
  logic                  sep5_nxt;
  logic signed [PLW-1:0] pl_r [3][2];
  logic signed [PHW-1:0] ph_r [3][2];
  logic [RPW-1:0]        rp_r [3][2];
  logic signed [PLW-1:0] pl_nxt [3][2];
  logic signed [PHW-1:0] ph_nxt [3][2];
  logic [RPW-1:0]        rp_nxt [3][2];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mid_mag[a]  = mid_r[a][MW-1] ? MW'(-mid_r[a]) : MW'(mid_r[a]);
      ext_mag[a]  = ext_r[a][MW-1] ? MW'(-ext_r[a]) : MW'(ext_r[a]);
      face_hit[a] = FW'(mid_mag[a]) >
                    (FW'(ext_mag[a]) + (FW'(hlen[a]) << (AXIS_FRAC_BITS + 1)));
    end
    sep5_nxt = |face_hit;
    for (int j = 0; j < 3; j++) begin
      pl_nxt[j][0] = PLW'(mid_r[PAIR_A[j]]) *
                     PLW'($signed({1'b0, ext_r[PAIR_B[j]][LO-1:0]}));
      ph_nxt[j][0] = PHW'(mid_r[PAIR_A[j]]) *
                     PHW'($signed(ext_r[PAIR_B[j]][MW-1:LO]));
      pl_nxt[j][1] = PLW'(mid_r[PAIR_B[j]]) *
                     PLW'($signed({1'b0, ext_r[PAIR_A[j]][LO-1:0]}));
      ph_nxt[j][1] = PHW'(mid_r[PAIR_B[j]]) *
                     PHW'($signed(ext_r[PAIR_A[j]][MW-1:LO]));
      rp_nxt[j][0] = RPW'(hlen[PAIR_A[j]]) * RPW'(ext_mag[PAIR_B[j]]);
      rp_nxt[j][1] = RPW'(hlen[PAIR_B[j]]) * RPW'(ext_mag[PAIR_A[j]]);
    end
  end

  // Stage 6: full cross products and projected box radius.
  logic                  sep6_r;
  logic signed [PPW-1:0] px_r [3][2];
  logic [RW-1:0]         rs_r [3];
  logic signed [PPW-1:0] px_nxt [3][2];
  logic [RW-1:0]         rs_nxt [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int t = 0; t < 2; t++) begin
        px_nxt[j][t] = (PPW'(ph_r[j][t]) <<< LO) + PPW'(pl_r[j][t]);
      end
      rs_nxt[j] = RW'(rp_r[j][0]) + RW'(rp_r[j][1]);
    end
  end

  // Stage 7: magnitude of the projected centre on each cross axis.
  logic                 sep7_r;
  logic [XW-1:0]        lhs_r [3];
  logic [RSW-1:0]       rhs_r [3];
  logic signed [XW-1:0] cdiff [3];
  logic [XW-1:0]        lhs_nxt [3];
  logic [RSW-1:0]       rhs_nxt [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cdiff[j]   = XW'(px_r[j][0]) - XW'(px_r[j][1]);
      lhs_nxt[j] = cdiff[j][XW-1] ? XW'(-cdiff[j]) : XW'(cdiff[j]);
      rhs_nxt[j] = RSW'(rs_r[j]) << (AXIS_FRAC_BITS + 1);
    end
  end

  // Stage 8: final decision.
  logic       ovl_r;
  logic       ovl_nxt;
  logic [2:0] cross_hit;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cross_hit[j] = CMPW'(lhs_r[j]) > CMPW'(rhs_r[j]);
    end
    ovl_nxt = !(sep7_r || (|cross_hit));
  end

  assign out_res.overlap = ovl_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pt_r <= pt_nxt;
    end
    if (en[2]) begin
      prod_r <= prod_nxt;
    end
    if (en[3]) begin
      dot_r <= dot_nxt;
    end
    if (en[4]) begin
      mid_r <= mid_nxt;
      ext_r <= ext_nxt;
    end
    if (en[5]) begin
      sep5_r <= sep5_nxt;
      pl_r   <= pl_nxt;
      ph_r   <= ph_nxt;
      rp_r   <= rp_nxt;
    end
    if (en[6]) begin
      sep6_r <= sep5_r;
      px_r   <= px_nxt;
      rs_r   <= rs_nxt;
    end
    if (en[7]) begin
      sep7_r <= sep6_r;
      lhs_r  <= lhs_nxt;
      rhs_r  <= rhs_nxt;
    end
    if (en[8]) begin
      ovl_r <= ovl_nxt;
    end
  end

  // An empty or draining output stage must never hold back the input side.
  `SOBB_ASSERT_IMM(a_ready_when_free, clk, rst_n, !out_res.valid || out_res.ready, in_seg.ready)
  // An accepted input beat occupies the first stage in the next cycle.
  `SOBB_ASSERT_NXT(a_accept_fills, clk, rst_n, in_seg.valid && in_seg.ready, vld_r[1])
  // A write to the first half-length lands in its register.
  `SOBB_ASSERT_NXT(a_half_write, clk, rst_n, cfg_wr && cfg_idx == sobb_pkg::REG_HALF_FIRST, half_r[0] == $past(pwdata[HALF_W-1:0]))

endmodule

[dv/tb_segment_obb_overlap_sat.sv]
module tb_segment_obb_overlap_sat;

  typedef struct packed {
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [15:0] start_z;
    logic [15:0] end_x;
    logic [15:0] end_y;
    logic [15:0] end_z;
  } segment_t;

  typedef enum int {
    BOX_SWAPPED,
    BOX_TURNED,
    BOX_SKEWED,
    BOX_EXTREME
  } box_style_t;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 120;
  localparam int HOLD_CYCLES   = 300;
  localparam int HALF_SHIFT    = sobb_pkg::AXIS_FRAC_BITS_DEF + 1;
  localparam logic [sobb_pkg::CFG_AW-1:0] SPARE_ADDR = 6'd56;
  localparam int ROT_TAB[5]  = '{16384, 15137, 11585, 6270, 0};
  localparam int EDGE_TAB[5] = '{-32768, 32767, 0, 16384, -16384};

  logic                        clk;
  logic                        rst_n;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [sobb_pkg::CFG_AW-1:0] paddr;
  logic [sobb_pkg::CFG_DW-1:0] pwdata;
  logic [sobb_pkg::CFG_DW-1:0] prdata;
  logic                        pready;

  sobb_in_if  in_seg ();
  sobb_out_if out_res ();

  segment_obb_overlap_sat DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_seg  (in_seg),
    .out_res (out_res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [47:0] centre_q;
  logic [47:0] axes_q [3];
  logic [15:0] halves_q [3];

  segment_t pending_segs[$];
  bit       overlap_q[$];

  int send_idle;
  int recv_idle;
  int hold_left = 0;
  bit in_taken  = 1'b0;
  int quiet;
  int mismatches;
  int results;
  int hits;
  int settings;
  int input_stalls;
  bit wanted;

  function automatic logic signed [127:0] mag(logic signed [127:0] v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [47:0] pack3(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic segment_t make_segment(int x1, int y1, int z1, int x2, int y2, int z2);
    segment_t s;
    s.start_x = 16'(x1);
    s.start_y = 16'(y1);
    s.start_z = 16'(z1);
    s.end_x   = 16'(x2);
    s.end_y   = 16'(y2);
    s.end_z   = 16'(z2);
    return s;
  endfunction

  // Endpoints go into box space at scale 2^14; m and w carry one extra bit, so the
  // half-lengths are shifted by 15 before any comparison. Every product fits in 128 bits.
  function automatic bit segment_hits_box(segment_t s);
    logic signed [127:0] first [3];
    logic signed [127:0] second [3];
    logic signed [127:0] m [3];
    logic signed [127:0] w [3];
    logic signed [127:0] h [3];
    logic signed [127:0] c;
    logic signed [127:0] d1;
    logic signed [127:0] d2;
    logic signed [127:0] ax;
    logic signed [127:0] lhs;
    logic signed [127:0] rhs;
    int a;
    int b;
    bit apart;
    apart = 1'b0;
    first[0]  = $signed(s.start_x);
    first[1]  = $signed(s.start_y);
    first[2]  = $signed(s.start_z);
    second[0] = $signed(s.end_x);
    second[1] = $signed(s.end_y);
    second[2] = $signed(s.end_z);
    for (int i = 0; i < 3; i++) begin
      c = $signed(centre_q[16*i +: 16]);
      first[i]  = first[i] - c;
      second[i] = second[i] - c;
      h[i] = halves_q[i];
    end
    for (int i = 0; i < 3; i++) begin
      d1 = 0;
      d2 = 0;
      for (int k = 0; k < 3; k++) begin
        ax = $signed(axes_q[i][16*k +: 16]);
        d1 = d1 + ax * first[k];
        d2 = d2 + ax * second[k];
      end
      m[i] = d1 + d2;
      w[i] = d2 - d1;
    end
    for (int i = 0; i < 3; i++) begin
      if (mag(m[i]) > mag(w[i]) + (h[i] <<< HALF_SHIFT)) apart = 1'b1;
    end
    for (int i = 0; i < 3; i++) begin
      a = (i == 0) ? 1 : 0;
      b = (i == 2) ? 1 : 2;
      lhs = mag(m[a] * w[b] - m[b] * w[a]);
      rhs = (h[a] * mag(w[b]) + h[b] * mag(w[a])) <<< HALF_SHIFT;
      if (lhs > rhs) apart = 1'b1;
    end
    return !apart;
  endfunction

  function automatic logic [15:0] near_coord(int axis);
    int reach;
    int v;
    reach = 400 + halves_q[0] + halves_q[1] + halves_q[2];
    v = $signed(centre_q[16*axis +: 16]) + int'($urandom_range(2 * reach)) - reach;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic segment_t random_segment();
    segment_t s;
    int pick;
    pick = $urandom_range(9);
    if (pick < 2) begin
      s = {$urandom, $urandom, $urandom};
    end else begin
      s.start_x = near_coord(0);
      s.start_y = near_coord(1);
      s.start_z = near_coord(2);
      if (pick == 2) begin
        s.end_x = s.start_x;
        s.end_y = s.start_y;
        s.end_z = s.start_z;
      end else begin
        s.end_x = near_coord(0);
        s.end_y = near_coord(1);
        s.end_z = near_coord(2);
      end
    end
    return s;
  endfunction

  task automatic apb_write(logic [sobb_pkg::CFG_AW-1:0] addr,
                           logic [sobb_pkg::CFG_DW-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(logic [sobb_pkg::CFG_AW-1:0] addr,
                          output logic [sobb_pkg::CFG_DW-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // The unused upper bits of each write carry noise, which the block must drop.
  task automatic write_reg(sobb_pkg::reg_idx_t idx, logic [47:0] value);
    logic [63:0] noise;
    logic [63:0] stored;
    logic [63:0] readback;
    noise = {$urandom, $urandom};
    case (idx)
      sobb_pkg::REG_BOX_CENTER: begin
        apb_write({idx, 3'b000}, {noise[63:48], value});
        centre_q = value;
        stored   = {16'd0, value};
      end
      sobb_pkg::REG_AXIS_FIRST, sobb_pkg::REG_AXIS_SECOND, sobb_pkg::REG_AXIS_THIRD: begin
        apb_write({idx, 3'b000}, {noise[63:48], value});
        axes_q[idx - sobb_pkg::REG_AXIS_FIRST] = value;
        stored = {16'd0, value};
      end
      default: begin
        apb_write({idx, 3'b000}, {noise[63:16], value[15:0]});
        halves_q[idx - sobb_pkg::REG_HALF_FIRST] = value[15:0];
        stored = {48'd0, value[15:0]};
      end
    endcase
    apb_read({idx, 3'b000}, readback);
    if (readback !== stored) begin
      $display("%0t: register %0d readback mismatch, expected %h, actual %h",
               $time, idx, stored, readback);
      mismatches++;
    end
  endtask

  task automatic set_box(logic [47:0] ctr, logic [47:0] ax0, logic [47:0] ax1,
                         logic [47:0] ax2, logic [15:0] h0, logic [15:0] h1,
                         logic [15:0] h2);
    write_reg(sobb_pkg::REG_BOX_CENTER, ctr);
    write_reg(sobb_pkg::REG_AXIS_FIRST, ax0);
    write_reg(sobb_pkg::REG_AXIS_SECOND, ax1);
    write_reg(sobb_pkg::REG_AXIS_THIRD, ax2);
    write_reg(sobb_pkg::REG_HALF_FIRST, {32'd0, h0});
    write_reg(sobb_pkg::REG_HALF_SECOND, {32'd0, h1});
    write_reg(sobb_pkg::REG_HALF_THIRD, {32'd0, h2});
    settings++;
  endtask

  task automatic random_box(box_style_t style);
    logic [47:0] ax [3];
    logic [15:0] hl [3];
    logic [47:0] ctr;
    int turn;
    turn = $urandom_range(4);
    for (int i = 0; i < 3; i++) ax[i] = '0;
    case (style)
      BOX_SWAPPED: begin
        for (int i = 0; i < 3; i++) begin
          ax[i][16*((i + turn) % 3) +: 16] = $urandom_range(1) ? -16'sd16384 : 16'sd16384;
        end
      end
      BOX_TURNED: begin
        ax[0] = pack3(ROT_TAB[turn], ROT_TAB[4-turn], 0);
        ax[1] = pack3(-ROT_TAB[4-turn], ROT_TAB[turn], 0);
        ax[2] = pack3(0, 0, 16384);
      end
      BOX_SKEWED: begin
        for (int i = 0; i < 3; i++) ax[i] = 48'({$urandom, $urandom});
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          ax[i] = pack3(EDGE_TAB[$urandom_range(4)], EDGE_TAB[$urandom_range(4)],
                        EDGE_TAB[$urandom_range(4)]);
        end
      end
    endcase
    case (style)
      BOX_EXTREME: begin
        ctr = pack3($urandom_range(1) ? 32767 : -32768, $urandom_range(1) ? 32767 : -32768,
                    $urandom_range(1) ? 32767 : -32768);
      end
      BOX_SKEWED: begin
        ctr = 48'({$urandom, $urandom});
      end
      default: begin
        ctr = pack3(int'($urandom_range(8000)) - 4000, int'($urandom_range(8000)) - 4000,
                    int'($urandom_range(8000)) - 4000);
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      if (style == BOX_EXTREME) hl[i] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      else hl[i] = 16'($urandom_range(3000));
    end
    set_box(ctr, ax[0], ax[1], ax[2], hl[0], hl[1], hl[2]);
  endtask

  task automatic drain();
    while (pending_segs.size() != 0 || overlap_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    if (!in_seg.valid || in_taken) begin
      in_taken = 1'b0;
      if (pending_segs.size() != 0 && $urandom_range(99) >= send_idle) begin
        in_seg.valid   <= 1'b1;
        in_seg.start_x <= pending_segs[0].start_x;
        in_seg.start_y <= pending_segs[0].start_y;
        in_seg.start_z <= pending_segs[0].start_z;
        in_seg.end_x   <= pending_segs[0].end_x;
        in_seg.end_y   <= pending_segs[0].end_y;
        in_seg.end_z   <= pending_segs[0].end_z;
      end else begin
        in_seg.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_res.ready <= 1'b0;
      hold_left--;
    end else begin
      out_res.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // The result beat is checked before the input beat of the same edge is predicted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_res.valid && out_res.ready) begin
        if (overlap_q.size() == 0) begin
          $display("%0t: result beat with none expected, expected none, actual overlap %0b",
                   $time, out_res.overlap);
          mismatches++;
        end else begin
          wanted = overlap_q.pop_front();
          results++;
          if (out_res.overlap === 1'b1) hits++;
          if (out_res.overlap !== wanted) begin
            $display("%0t: overlap mismatch, expected %0b, actual %0b",
                     $time, wanted, out_res.overlap);
            mismatches++;
          end
        end
      end
      if (in_seg.valid && in_seg.ready) begin
        overlap_q.push_back(segment_hits_box(pending_segs[0]));
        void'(pending_segs.pop_front());
        in_taken = 1'b1;
      end else if (in_seg.valid) begin
        input_stalls++;
      end
      if ((in_seg.valid && in_seg.ready) || (out_res.valid && out_res.ready) || psel) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, quiet);
        $display("tb_segment_obb_overlap_sat NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_seg.valid   = 1'b0;
    in_seg.start_x = '0;
    in_seg.start_y = '0;
    in_seg.start_z = '0;
    in_seg.end_x   = '0;
    in_seg.end_y   = '0;
    in_seg.end_z   = '0;
    out_res.ready  = 1'b0;
    quiet          = 0;
    mismatches     = 0;
    results        = 0;
    hits           = 0;
    settings       = 1;
    input_stalls   = 0;
    send_idle      = 34;
    recv_idle      = 52;
    centre_q       = '0;
    axes_q[0]      = pack3(16384, 0, 0);
    axes_q[1]      = pack3(0, 16384, 0);
    axes_q[2]      = pack3(0, 0, 16384);
    for (int i = 0; i < 3; i++) halves_q[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Box out of reset is a single point at the origin.
    @(posedge clk);
    pending_segs.push_back(make_segment(0, 0, 0, 0, 0, 0));
    pending_segs.push_back(make_segment(1, 0, 0, 1, 0, 0));
    pending_segs.push_back(make_segment(-5, 0, 0, 5, 0, 0));
    pending_segs.push_back(make_segment(-5, 1, 0, 5, 1, 0));
    pending_segs.push_back(make_segment(-32768, -32768, -32768, 32767, 32767, 32767));
    drain();

    set_box(pack3(100, -200, 50), pack3(16384, 0, 0), pack3(0, 16384, 0),
            pack3(0, 0, 16384), 16'd1000, 16'd500, 16'd2000);
    apb_write(SPARE_ADDR, '1);
    @(posedge clk);
    pending_segs.push_back(make_segment(100, -200, 50, 100, -200, 50));
    pending_segs.push_back(make_segment(1100, -200, 50, 1100, -200, 50));
    pending_segs.push_back(make_segment(1101, -200, 50, 1101, -200, 50));
    pending_segs.push_back(make_segment(-3000, -200, 50, 3000, -200, 50));
    pending_segs.push_back(make_segment(2100, -200, 50, 100, 800, 50));
    pending_segs.push_back(make_segment(2200, -200, 50, 100, 850, 50));
    pending_segs.push_back(make_segment(-32768, -32768, -32768, 32767, 32767, 32767));
    pending_segs.push_back(make_segment(32767, -32768, 32767, -32768, 32767, -32768));
    drain();

    set_box(pack3(-32768, 32767, -32768), pack3(-32768, 32767, 0), pack3(0, -32768, 32767),
            pack3(32767, 0, -32768), 16'hFFFF, 16'hFFFF, 16'hFFFF);
    @(posedge clk);
    pending_segs.push_back(make_segment(-32768, -32768, -32768, -32768, -32768, -32768));
    pending_segs.push_back(make_segment(32767, 32767, 32767, 32767, 32767, 32767));
    pending_segs.push_back(make_segment(-32768, 32767, -32768, -32768, 32767, -32768));
    pending_segs.push_back(make_segment(32767, -32768, 32767, -32768, 32767, -32768));
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      random_box(box_style_t'(phase % 4));
      @(posedge clk);
      if (phase == PHASES / 3) begin
        send_idle = 52;
        recv_idle = 34;
      end
      if (phase == 2 * PHASES / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (phase == 2 * PHASES / 3 + 1) hold_left = HOLD_CYCLES;
      repeat (PHASE_ITEMS) pending_segs.push_back(random_segment());
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d segment queries against %0d box settings: %0d overlapping, %0d apart.",
             results, settings, hits, results - hits);
    $display("Input beats were held back for %0d cycles, a long output stall among them.",
             input_stalls);
    if (mismatches == 0) begin
      $display("tb_segment_obb_overlap_sat OK");
    end else begin
      $display("tb_segment_obb_overlap_sat NOT OK");
    end
    $finish;
  end

endmodule
